// File: rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned DataW    = 32;
  localparam int unsigned FillW    = 5;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } spq_op_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_POPPED    = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } spq_status_e;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] prio;
  } spq_entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic       insert;
    logic       pop;
    spq_entry_t entry;
  } spq_cmd_t;

endpackage

`default_nettype wire

// File: rtl/spq_in_if.sv
`default_nettype none

interface spq_in_if;
  import spq_pkg::*;

  logic                    valid;
  logic                    ready;
  spq_op_e                 op;
  logic signed [DataW-1:0] item_value;
  logic signed [DataW-1:0] item_prio;

  modport source (output valid, op, item_value, item_prio, input ready);
  modport sink   (input valid, op, item_value, item_prio, output ready);
endinterface

`default_nettype wire

// File: rtl/spq_out_if.sv
`default_nettype none

interface spq_out_if;
  import spq_pkg::*;

  logic                    valid;
  logic                    ready;
  spq_status_e             status;
  logic signed [DataW-1:0] out_value;
  logic signed [DataW-1:0] out_priority;
  logic [FillW-1:0]        fill_level;

  modport source (output valid, status, out_value, out_priority, fill_level, input ready);
  modport sink   (input valid, status, out_value, out_priority, fill_level, output ready);
endinterface

`default_nettype wire

// File: rtl/stable_priority_queue_core.sv
`default_nettype none

// Bounded priority queue of spq_pkg::Capacity entries, kept sorted in a row of
// cells with slot 0 at the front. An insert item lands behind every held entry
// whose signed priority is less than or equal to its own, so smaller numbers
// leave first and equal priorities leave in arrival order; a pop item removes
// the front entry. Every item gives exactly one result item: status, the popped
// value and priority (zero unless popped) and the fill level after the item.
// A pop on an empty queue reports underflow and an insert on a full queue
// reports overflow; neither changes the contents. All cells compare their
// priority with the new one in parallel and shift one place in the same edge,
// and the result sits in an output register in the cycle after acceptance. A
// new item is taken whenever that register is empty or is being drained, so
// one item per cycle is sustained. No clearing pass after reset: only the entry
// count and output valid are cleared; cells past the count are never read.
module stable_priority_queue_core (
  input  logic clk_i,
  input  logic rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);
  import spq_pkg::*;

  // entry count and derived flags
  logic [CountW-1:0] count_q, count_d;
  logic              full, empty;
  logic              accept;
  spq_cmd_t          cmd;

  // neighbor links of the cell row
  logic       keep  [Capacity];
  spq_entry_t entry [Capacity];

  // output register
  logic             out_valid_q;
  spq_status_e      status_q, status_d;
  spq_entry_t       res_q, res_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [CountW+FillW-1:0] count_ext;

  assign full   = (count_q == CountW'(Capacity));
  assign empty  = (count_q == '0);
  assign accept = in_i.valid && in_i.ready;

  // input side stalls only while an unread result blocks the register
  assign in_i.ready = !out_valid_q || out_o.ready;

  always_comb begin
    cmd.insert     = accept && (in_i.op == OP_INSERT) && !full;
    cmd.pop        = accept && (in_i.op == OP_POP) && !empty;
    cmd.entry.value = in_i.item_value;
    cmd.entry.prio  = in_i.item_prio;
  end

  // row of compare and shift cells
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic       occupied;
    logic       prev_keep;
    spq_entry_t prev_entry;
    spq_entry_t next_entry;

    assign occupied = (count_q > CountW'(i));

    if (i == 0) begin : g_head
      // the front slot takes the new entry unless it keeps its own
      assign prev_keep  = 1'b1;
      assign prev_entry = cmd.entry;
    end else begin : g_body
      assign prev_keep  = keep[i-1];
      assign prev_entry = entry[i-1];
    end

    if (i == Capacity - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = entry[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occupied_i   (occupied),
      .prev_keep_i  (prev_keep),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .keep_o       (keep[i]),
      .entry_o      (entry[i])
    );
  end

  // count update and result formation
  always_comb begin
    count_d  = count_q;
    status_d = ST_INSERTED;
    res_d    = '0;
    if (in_i.op == OP_INSERT) begin
      if (full) begin
        status_d = ST_OVERFLOW;
      end else begin
        count_d  = count_q + CountW'(1);
      end
    end else begin
      if (empty) begin
        status_d = ST_UNDERFLOW;
      end else begin
        status_d = ST_POPPED;
        res_d    = entry[0];
        count_d  = count_q - CountW'(1);
      end
    end
  end

  // fill level is the count reduced to the field width
  assign count_ext = {{FillW{1'b0}}, count_d};
  assign fill_d    = count_ext[FillW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      res_q    <= res_d;
      fill_q   <= fill_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.out_value    = res_q.value;
  assign out_o.out_priority = res_q.prio;
  assign out_o.fill_level   = fill_q;

endmodule

`default_nettype wire

// File: rtl/spq_cell.sv
`default_nettype none

module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::spq_cmd_t   cmd_i,
  input  logic               occupied_i,
  input  logic               prev_keep_i,
  input  spq_pkg::spq_entry_t prev_entry_i,
  input  spq_pkg::spq_entry_t next_entry_i,
  output logic               keep_o,
  output spq_pkg::spq_entry_t entry_o
);
  import spq_pkg::*;

  spq_entry_t entry_q, entry_d;

  // an occupied slot at or below the new priority stays put on insert
  assign keep_o  = occupied_i && (entry_q.prio <= cmd_i.entry.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.insert && !keep_o) begin
      entry_d = prev_keep_i ? cmd_i.entry : prev_entry_i;
    end else if (cmd_i.pop) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire
